// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker module of the scaler.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold on the edge after reset was sampled low.
`define CHK_AFTER_RESET(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (prop)) else $error(msg);

`endif

// ----- rtl/cnsb_pkg.sv -----
// Package of the centred nearest-neighbour scale blitter: widths, register
// indexes, reset values, controller command and status types, axis layout.
// No dependencies.
package cnsb_pkg;

    localparam int DIM_W      = 13;
    localparam int ADDR_W     = 26;
    localparam int BPP_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = DIM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Frame buffer pixels are four bytes wide.
    localparam int FRAME_BPP_SHIFT = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = ((2 * ADDR_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BPP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT= 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd6;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [BPP_W-1:0] RST_BPP    = 3'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic eval;
        logic prep;
        logic div_start;
        logic mult;
        logic addr;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic div_done;
        logic out_free;
    } status_t;

    // Visible span, frame offset and view crop along one axis.
    typedef struct packed {
        logic [DIM_W-1:0] fill;
        logic [DIM_W-1:0] off;
        logic [DIM_W-1:0] crop;
    } layout_t;

    function automatic layout_t axis_layout(input logic [DIM_W-1:0] view,
                                            input logic [DIM_W-1:0] frame);
        layout_t l;
        if (view > frame) begin
            l.fill = frame;
            l.off  = '0;
            l.crop = DIM_W'((view - frame) >> 1);
        end else begin
            l.fill = view;
            l.off  = DIM_W'((frame - view) >> 1);
            l.crop = '0;
        end
        return l;
    endfunction

endpackage

// ----- rtl/cnsb_div.sv -----
// Restoring divider, one quotient bit per cycle, for the source row/column.
// Depends on cnsb_pkg. The quotient must fit in DIM_W bits.
module cnsb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cnsb_pkg::ADDR_W-1:0]   dividend,
    input  logic [cnsb_pkg::DIM_W-1:0]    divisor,
    output logic                          done,
    output logic [cnsb_pkg::DIM_W-1:0]    quotient
);

    logic                              busy_reg;
    logic [cnsb_pkg::DIV_CNT_W-1:0]    count_reg;
    logic [cnsb_pkg::DIM_W-1:0]        rem_reg;
    logic [cnsb_pkg::DIM_W-1:0]        low_reg;
    logic [cnsb_pkg::DIM_W-1:0]        quo_reg;

    logic [cnsb_pkg::DIM_W:0]          rem_shift;
    logic [cnsb_pkg::DIM_W:0]          diff;
    logic                              ge;
    logic [cnsb_pkg::DIM_W-1:0]        rem_step;

    always_comb begin
        rem_shift = {rem_reg, low_reg[cnsb_pkg::DIM_W-1]};
        ge        = rem_shift >= {1'b0, divisor};
        diff      = rem_shift - {1'b0, divisor};
        rem_step  = ge ? diff[cnsb_pkg::DIM_W-1:0] : rem_shift[cnsb_pkg::DIM_W-1:0];
    end

    assign done     = busy_reg && (count_reg == cnsb_pkg::DIV_CNT_W'(1));
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            count_reg <= cnsb_pkg::DIV_CNT_W'(cnsb_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            count_reg <= count_reg - cnsb_pkg::DIV_CNT_W'(1);
            if (count_reg == cnsb_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[cnsb_pkg::ADDR_W-1:cnsb_pkg::DIM_W];
            low_reg <= dividend[cnsb_pkg::DIM_W-1:0];
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            low_reg <= {low_reg[cnsb_pkg::DIM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[cnsb_pkg::DIM_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/cnsb_datapath.sv -----
// Datapath of the scaler: configuration registers, scan position, address
// arithmetic with two dividers, and the output register.
// Depends on cnsb_pkg and cnsb_div.
module cnsb_datapath #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cnsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cnsb_pkg::DIM_W-1:0]        cfg_data,
    input  logic                              restart,
    input  cnsb_pkg::cmd_t                    cmd,
    output cnsb_pkg::status_t                 status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [cnsb_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic [cnsb_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int DW = cnsb_pkg::DIM_W;
    localparam int AW = cnsb_pkg::ADDR_W;
    localparam int BW = cnsb_pkg::BPP_W;
    localparam logic [DW-1:0] DIM_CAP = DW'(MAX_DIM);

    // Configuration
    logic [DW-1:0] src_width_reg, src_height_reg;
    logic [BW-1:0] src_bpp_reg;
    logic [DW-1:0] frame_width_reg, frame_height_reg;
    logic [DW-1:0] view_width_reg, view_height_reg;
    logic [DW-1:0] cfg_sat;

    cnsb_pkg::layout_t lay_x_reg, lay_y_reg;

    // Scan state
    logic [DW-1:0] scan_row_reg, scan_row_next;
    logic [DW-1:0] scan_col_reg, scan_col_next;
    logic          frame_done_reg, frame_done_next;
    logic          restart_reg;

    // Per-pixel working registers
    logic          hit_reg, rlast_reg, flast_reg;
    logic [DW-1:0] vy_reg, vx_reg, drow_reg, dcol_reg;
    logic [AW-1:0] num_y_reg, num_x_reg, dlin_reg, sprod_reg;
    logic [AW-1:0] src_addr_reg, dest_addr_reg;

    logic [DW-1:0] row_eff, col_eff;
    logic          done_eff, hit, rlast, flast;
    logic [DW:0]   col_inc, row_inc;

    logic          div_y_done, div_x_done;
    logic [DW-1:0] srow, scol;

    logic [AW-1:0]    ssum, dsum;
    logic [AW+BW-1:0] src_wide;
    logic [AW+cnsb_pkg::FRAME_BPP_SHIFT-1:0] dest_wide;

    // Output register
    logic          m_tvalid_reg;
    logic [AW-1:0] out_dest_reg, out_src_reg;
    logic          out_valid_reg, out_rlast_reg, out_flast_reg;

    assign cfg_sat = (int'(cfg_data) > MAX_DIM) ? DIM_CAP : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg    <= cnsb_pkg::RST_WIDTH;
            src_height_reg   <= cnsb_pkg::RST_HEIGHT;
            src_bpp_reg      <= cnsb_pkg::RST_BPP;
            frame_width_reg  <= cnsb_pkg::RST_WIDTH;
            frame_height_reg <= cnsb_pkg::RST_HEIGHT;
            view_width_reg   <= cnsb_pkg::RST_WIDTH;
            view_height_reg  <= cnsb_pkg::RST_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                cnsb_pkg::REG_SRC_WIDTH:    src_width_reg    <= cfg_sat;
                cnsb_pkg::REG_SRC_HEIGHT:   src_height_reg   <= cfg_sat;
                cnsb_pkg::REG_SRC_BPP:      src_bpp_reg      <= cfg_data[BW-1:0];
                cnsb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_sat;
                cnsb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_sat;
                cnsb_pkg::REG_VIEW_WIDTH:   view_width_reg   <= cfg_sat;
                cnsb_pkg::REG_VIEW_HEIGHT:  view_height_reg  <= cfg_sat;
                default: begin
                end
            endcase
        end
    end

    // The window layout follows the registers in the next cycle.
    always_ff @(posedge aclk) begin
        lay_x_reg <= cnsb_pkg::axis_layout(view_width_reg, frame_width_reg);
        lay_y_reg <= cnsb_pkg::axis_layout(view_height_reg, frame_height_reg);
    end

    always_comb begin
        row_eff  = restart_reg ? '0 : scan_row_reg;
        col_eff  = restart_reg ? '0 : scan_col_reg;
        done_eff = restart_reg ? 1'b0 : frame_done_reg;
        hit      = !done_eff && (lay_x_reg.fill != '0) && (lay_y_reg.fill != '0)
                   && (row_eff < lay_y_reg.fill) && (col_eff < lay_x_reg.fill);
        col_inc  = {1'b0, col_eff} + (DW+1)'(1);
        row_inc  = {1'b0, row_eff} + (DW+1)'(1);
        rlast    = col_inc >= {1'b0, lay_x_reg.fill};
        flast    = rlast && (row_inc >= {1'b0, lay_y_reg.fill});

        scan_row_next   = row_eff;
        scan_col_next   = col_eff;
        frame_done_next = 1'b1;
        if (hit) begin
            frame_done_next = flast;
            if (flast) begin
                scan_row_next = '0;
                scan_col_next = '0;
            end else if (rlast) begin
                scan_col_next = '0;
                scan_row_next = row_inc[DW-1:0];
            end else begin
                scan_col_next = col_inc[DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            frame_done_reg <= 1'b1;
            restart_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                restart_reg <= restart;
            end
            if (cmd.eval) begin
                scan_row_reg   <= scan_row_next;
                scan_col_reg   <= scan_col_next;
                frame_done_reg <= frame_done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            hit_reg   <= hit;
            rlast_reg <= hit && rlast;
            flast_reg <= hit && flast;
            vy_reg    <= lay_y_reg.crop + row_eff;
            vx_reg    <= lay_x_reg.crop + col_eff;
            drow_reg  <= lay_y_reg.off + row_eff;
            dcol_reg  <= lay_x_reg.off + col_eff;
        end
        if (cmd.prep) begin
            num_y_reg <= vy_reg * src_height_reg;
            num_x_reg <= vx_reg * src_width_reg;
            dlin_reg  <= drow_reg * frame_width_reg;
        end
        if (cmd.mult) begin
            sprod_reg <= srow * src_width_reg;
        end
        if (cmd.addr) begin
            src_addr_reg  <= src_wide[AW-1:0];
            dest_addr_reg <= dest_wide[AW-1:0];
        end
    end

    cnsb_div u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_y_reg),
        .divisor  (view_height_reg),
        .done     (div_y_done),
        .quotient (srow)
    );

    cnsb_div u_div_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_x_reg),
        .divisor  (view_width_reg),
        .done     (div_x_done),
        .quotient (scol)
    );

    always_comb begin
        ssum      = sprod_reg + AW'(scol);
        src_wide  = ssum * src_bpp_reg;
        dsum      = dlin_reg + AW'(dcol_reg);
        dest_wide = {dsum, {cnsb_pkg::FRAME_BPP_SHIFT{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // A result that names no pixel carries all-zero fields.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_valid_reg <= hit_reg;
            out_rlast_reg <= rlast_reg;
            out_flast_reg <= flast_reg;
            out_dest_reg  <= hit_reg ? dest_addr_reg : '0;
            out_src_reg   <= hit_reg ? src_addr_reg : '0;
        end
    end

    assign status.hit      = hit_reg;
    assign status.div_done = div_y_done && div_x_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(cnsb_pkg::M_TDATA_W - 2 * AW){1'b0}}, out_src_reg, out_dest_reg};
    assign m_tlast  = out_rlast_reg;
    assign m_tuser  = {out_flast_reg, out_valid_reg};

endmodule

// ----- rtl/cnsb_ctrl.sv -----
// Controller of the scaler: sequences one step item through evaluation,
// products, division, address assembly and the output register.
// Depends on cnsb_pkg.
module cnsb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cnsb_pkg::status_t status,
    output cnsb_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EVAL   = 8'b0000_0010,
        ST_PREP   = 8'b0000_0100,
        ST_DSTART = 8'b0000_1000,
        ST_DIVIDE = 8'b0001_0000,
        ST_MULT   = 8'b0010_0000,
        ST_ADDR   = 8'b0100_0000,
        ST_OUTPUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.hit ? ST_DSTART : ST_OUTPUT;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/centered_nearest_scale_blit.sv -----
// Top level of the centred nearest-neighbour scale blitter.
// Depends on cnsb_pkg, cnsb_ctrl and cnsb_datapath (with cnsb_div).
//
// Each beat on the slave stream is one step of the scan: s_tdata bit 0 set
// starts a new frame at its first visible pixel, clear advances one pixel.
// Every step beat yields exactly one beat on the master stream, giving the
// byte address of the frame buffer pixel and of the nearest source pixel.
// A result beat whose valid flag (m_tuser bit 0) is low names no pixel: the
// frame has ended or the window is empty, and all its other fields are zero.
// m_tlast marks the last pixel of a visible row, m_tuser bit 1 the last
// pixel of the frame.
// The block works on one step at a time. A visible pixel passes through the
// 13-step restoring dividers that find the source row and column before its
// result beat; a step that names no pixel skips them. The next step is
// accepted as soon as the result has moved into the output register, so a
// stalled receiver holds only that one beat; a further result waits in the
// controller until the register frees. Registers are written through the
// cfg channel, which is always ready; write them only while no step is in
// flight. Reset restores the default 640x480 layout, clears the output and
// leaves no frame active.
module centered_nearest_scale_blit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Slave stream: tdata = restart (bit 0), zero padded.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cnsb_pkg::S_TDATA_W-1:0]    s_tdata,
    // Master stream: tdata = dest_address [25:0], source_address [51:26].
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cnsb_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // tuser = valid_res (bit 0), frame_last (bit 1).
    output logic [cnsb_pkg::M_TUSER_W-1:0]    m_tuser,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cnsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cnsb_pkg::DIM_W-1:0]        cfg_data
);

    cnsb_pkg::cmd_t    cmd;
    cnsb_pkg::status_t status;

    // Writes go straight into registers, so the channel never stalls.
    assign cfg_ready = 1'b1;

    cnsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cnsb_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (s_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/cnsb_chk.sv -----
// Port-level checker of the scale blitter, bound to the top level.
// Depends on cnsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cnsb_chk (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [cnsb_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    input  logic [cnsb_pkg::M_TUSER_W-1:0]    m_tuser
);

    // A stalled result beat keeps its contents.
    `CHK_ALWAYS(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result beat changed")

    // A beat that names no pixel carries only zeros.
    `CHK_ALWAYS(a_invalid_zero, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tlast && !m_tuser[1]), "invalid result beat has nonzero fields")

    // The frame's last pixel also ends its row.
    `CHK_ALWAYS(a_frame_row_last, aclk, aresetn, (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0]), "frame end without row end")

    // Frame buffer addresses fall on whole pixels.
    `CHK_ALWAYS(a_dest_aligned, aclk, aresetn, m_tvalid |-> (m_tdata[1:0] == 2'b00), "destination address not pixel aligned")

    // Reset empties the output register.
    `CHK_AFTER_RESET(a_reset_empty, aclk, aresetn, !m_tvalid, "result beat present after reset")

endmodule

bind centered_nearest_scale_blit cnsb_chk u_cnsb_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
